// ===== design/lafu_pkg.sv =====
`default_nettype none
package lafu_pkg;

  localparam int VOCAB_DEF      = 32;
  localparam int MODEL_DIM_DEF  = 32;
  localparam int SEQ_LEN_DEF    = 16;
  localparam int DATA_WIDTH_DEF = 16;

  localparam int FRAC        = 11;
  localparam int ONE_Q       = 2048;
  localparam int EXP_DEPTH   = 256;
  localparam int LOGIT_MAX   = 8388607;
  localparam int MAX_RESULTS = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_TOKEN   = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [2:0] MAT_EMBED = 3'd0;
  localparam logic [2:0] MAT_QUERY = 3'd1;
  localparam logic [2:0] MAT_KEY   = 3'd2;
  localparam logic [2:0] MAT_VALUE = 3'd3;
  localparam logic [2:0] MAT_OUT   = 3'd4;

  typedef enum logic [1:0] {CMD_WEIGHT, CMD_TOKEN, CMD_COMPUTE} cmd_kind_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         matrix_sel;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [15:0] weight_value;
    logic [3:0]         position;
    logic [4:0]         token;
  } req_t;

  typedef struct packed {
    logic [4:0]         logit_index;
    logic signed [23:0] logit;
    logic               last;
  } res_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         matrix_sel;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [15:0] weight_value;
    logic [3:0]         position;
    logic [4:0]         token;
  } cmd_t;

  function automatic int bits_for(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // exp(-i/32) in Q.11, geometric recurrence in Q.30
  function automatic logic [EXP_DEPTH*16-1:0] exp_rom_init();
    logic [63:0] p;
    logic [63:0] e;
    logic [EXP_DEPTH*16-1:0] r;
    p = 64'd1 << 30;
    r = '0;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      e = (p + (64'd1 << 18)) >> 19;
      r[i*16 +: 16] = e[15:0];
      p = (p * 64'd1040706261 + (64'd1 << 29)) >> 30;
    end
    return r;
  endfunction

  localparam logic [EXP_DEPTH*16-1:0] EXP_ROM = exp_rom_init();

endpackage
`default_nettype wire

// ===== design/lafu_front.sv =====
`default_nettype none
module lafu_front import lafu_pkg::*; #(
  parameter int VOCAB     = VOCAB_DEF,
  parameter int MODEL_DIM = MODEL_DIM_DEF,
  parameter int SEQ_LEN   = SEQ_LEN_DEF
) (
  input  wire logic start,
  input  wire req_t request,
  input  wire logic full,
  output logic      busy,
  output logic      push,
  output cmd_t      cmd
);

  int  rows;
  logic ok;

  assign busy = full;

  always_comb begin
    rows = 0;
    case (request.matrix_sel)
      MAT_EMBED, MAT_OUT:              rows = VOCAB;
      MAT_QUERY, MAT_KEY, MAT_VALUE:   rows = MODEL_DIM;
      default:                         rows = 0;
    endcase
    cmd.matrix_sel   = request.matrix_sel;
    cmd.row_index    = request.row_index;
    cmd.col_index    = request.col_index;
    cmd.weight_value = request.weight_value;
    cmd.position     = request.position;
    cmd.token        = request.token;
    cmd.kind         = CMD_WEIGHT;
    ok               = 1'b0;
    case (request.op)
      OP_WEIGHT: begin
        cmd.kind = CMD_WEIGHT;
        ok = (int'(request.row_index) < rows) && (int'(request.col_index) < MODEL_DIM);
      end
      OP_TOKEN: begin
        cmd.kind = CMD_TOKEN;
        ok = int'(request.position) < SEQ_LEN;
      end
      OP_COMPUTE: begin
        cmd.kind = CMD_COMPUTE;
        ok = int'(request.position) < SEQ_LEN;
      end
      default: ok = 1'b0;
    endcase
  end

  // out-of-range beats are dropped here and never reach the queue
  assign push = start && !full && ok;

endmodule
`default_nettype wire

// ===== design/lafu_queue.sv =====
`default_nettype none
module lafu_queue import lafu_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head,
  output logic      full
);

  localparam int AW = bits_for(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t           slots [DEPTH];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  count;

  assign head_valid = count != '0;
  assign full       = int'(count) == DEPTH;
  assign head       = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (int'(wp) == DEPTH - 1) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (int'(rp) == DEPTH - 1) ? '0 : rp + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lafu_div.sv =====
`default_nettype none
module lafu_div #(
  parameter int NW = 41,
  parameter int ZW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [ZW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CW = $clog2(NW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [ZW-1:0] rem;
  logic [ZW-1:0] dvs;
  logic [NW-1:0] quo;
  logic [ZW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign trial    = {rem, quo[NW-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
        rem <= '0;
        dvs <= divisor;
        quo <= dividend;
      end else if (run) begin
        rem <= fits ? ZW'(trial - {1'b0, dvs}) : ZW'(trial);
        quo <= {quo[NW-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/lafu_back.sv =====
`default_nettype none
module lafu_back import lafu_pkg::*; #(
  parameter int VOCAB      = VOCAB_DEF,
  parameter int MODEL_DIM  = MODEL_DIM_DEF,
  parameter int SEQ_LEN    = SEQ_LEN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      result_valid,
  output res_t      result
);

  localparam int DW   = DATA_WIDTH;
  localparam int MD   = MODEL_DIM;
  localparam int NRES = (VOCAB < MAX_RESULTS) ? VOCAB : MAX_RESULTS;
  localparam int IW   = bits_for(MD);
  localparam int PW   = bits_for(SEQ_LEN);
  localparam int OW   = bits_for(max_int(SEQ_LEN, NRES));
  localparam int WW   = max_int(DW, 12);
  localparam int ZW   = WW + PW + 1;
  localparam int PRW  = 2 * WW + 2;
  localparam int ACCW = max_int(PRW + IW + PW + 2, 36);
  localparam int NW   = ACCW + 1;
  localparam int EAW  = bits_for(VOCAB * MD);
  localparam int SAW  = bits_for(MD * MD);
  localparam int KAW  = bits_for(SEQ_LEN * MD);
  localparam longint SAT_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint SAT_MIN = -(longint'(1) << (DW - 1));

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_DRAIN, S_WGT, S_DV_RD, S_DV_GO, S_DV_WAIT
  } state_t;

  typedef enum logic [1:0] {PH_KVQ, PH_SC, PH_AC, PH_LG} phase_t;

  typedef struct packed {
    logic          valid;
    logic [OW-1:0] o;
    logic [IW-1:0] m;
    logic [IW-1:0] n;
    logic          first;
    logic          last;
  } ctrl_t;

  function automatic logic signed [ACCW-1:0] rnd(input logic signed [ACCW-1:0] x);
    return (x + $signed(ACCW'(ONE_Q / 2))) >>> FRAC;
  endfunction

  function automatic logic signed [DW-1:0] sat_d(input logic signed [ACCW-1:0] x);
    if (x > SAT_MAX) begin
      return DW'(SAT_MAX);
    end else if (x < SAT_MIN) begin
      return DW'(SAT_MIN);
    end
    return DW'(x);
  endfunction

  function automatic logic signed [23:0] clamp24(input logic signed [ACCW-1:0] x);
    if (x > LOGIT_MAX) begin
      return 24'(LOGIT_MAX);
    end else if (x < -LOGIT_MAX - 1) begin
      return 24'(-LOGIT_MAX - 1);
    end
    return 24'(x);
  endfunction

  function automatic logic signed [WW:0] sx(input logic signed [DW-1:0] v);
    return $signed({{(WW + 1 - DW){v[DW-1]}}, v});
  endfunction

  function automatic logic signed [ACCW-1:0] ext(input logic signed [PRW-1:0] p);
    return $signed({{(ACCW - PRW){p[PRW-1]}}, p});
  endfunction

  // storage
  logic signed [DW-1:0]   embed_mem [VOCAB*MD];
  logic signed [DW-1:0]   wq_mem    [MD*MD];
  logic signed [DW-1:0]   wk_mem    [MD*MD];
  logic signed [DW-1:0]   wv_mem    [MD*MD];
  logic signed [DW-1:0]   wo_mem    [VOCAB*MD];
  logic [4:0]             tok_mem   [SEQ_LEN];
  logic signed [DW-1:0]   k_mem     [SEQ_LEN*MD];
  logic signed [DW-1:0]   v_mem     [SEQ_LEN*MD];
  logic signed [DW-1:0]   q_mem     [MD];
  logic signed [DW-1:0]   y_mem     [MD];
  logic signed [ACCW-1:0] acc_mem   [MD];

  state_t                 state;
  phase_t                 phase;
  logic [OW-1:0]          o;
  logic [IW-1:0]          m;
  logic [IW-1:0]          n;
  logic [IW-1:0]          dv_d;
  logic                   dv_neg;
  logic [3:0]             pos_r;
  logic signed [DW-1:0]   score;
  logic [WW-1:0]          w;
  logic [WW-1:0]          w_next;
  logic [ZW-1:0]          z;

  ctrl_t c0, ca, cb, cc;
  logic [4:0]             tok_a;
  logic signed [DW-1:0]   emb_b, wq_b, wk_b, wv_b, wo_b, q_b, k_b, v_b, y_b;
  logic                   xok_b;
  logic signed [ACCW-1:0] acc_b, acc_c;
  logic signed [DW-1:0]   x_b;
  logic signed [WW:0]     ma, mb;
  logic signed [PRW-1:0]  p0, p1, p2;
  logic signed [ACCW-1:0] acc0, acc1, acc2;
  logic signed [ACCW-1:0] sum0, sum1, sum2;

  int  nlim, mlim, olim;
  logic n_wrap, m_wrap, o_wrap, pipe_empty;

  logic [EAW-1:0] we_addr;
  logic [SAW-1:0] ws_addr;
  logic signed [DW-1:0] w_sat;
  logic [IW-1:0]  acc_ra;

  logic           div_start, div_done;
  logic [NW-1:0]  div_num, div_q;
  logic [ACCW-1:0] acc_mag;
  logic signed [DW-1:0] y_next;

  logic signed [ACCW-1:0] score_x, neg_x;
  logic [7:0]             exp_idx;

  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign pipe_empty = !ca.valid && !cb.valid && !cc.valid;

  // ---- loads ----
  assign we_addr = EAW'(int'(cmd.row_index) * MD + int'(cmd.col_index));
  assign ws_addr = SAW'(int'(cmd.row_index) * MD + int'(cmd.col_index));
  assign w_sat   = sat_d($signed({{(ACCW - 16){cmd.weight_value[15]}}, cmd.weight_value}));

  function automatic logic wsel(input cmd_t c, input logic [2:0] s);
    return c.kind == CMD_WEIGHT && c.matrix_sel == s;
  endfunction

  // ---- issue counters and limits ----
  always_comb begin
    nlim = MD;
    mlim = 1;
    olim = 1;
    case (phase)
      PH_KVQ: begin nlim = MD; mlim = MD; olim = SEQ_LEN; end
      PH_SC:  begin nlim = MD; mlim = 1;  olim = 1;       end
      PH_AC:  begin nlim = 1;  mlim = MD; olim = 1;       end
      PH_LG:  begin nlim = MD; mlim = 1;  olim = NRES;    end
      default: begin nlim = MD; mlim = 1; olim = 1;       end
    endcase
    n_wrap = int'(n) == nlim - 1;
    m_wrap = int'(m) == mlim - 1;
    o_wrap = (phase == PH_SC) || (phase == PH_AC) || (int'(o) == olim - 1);
    c0.valid = state == S_RUN;
    c0.o     = o;
    c0.m     = m;
    c0.n     = n;
    c0.first = n == '0;
    c0.last  = n_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ca <= '0;
      cb <= '0;
      cc <= '0;
    end else begin
      ca <= c0;
      cb <= ca;
      cc <= cb;
    end
  end

  // ---- memories ----
  always_ff @(posedge clk) begin
    if (cmd_pop && wsel(cmd, MAT_EMBED)) embed_mem[we_addr] <= w_sat;
    emb_b <= embed_mem[EAW'(int'(tok_a) * MD + int'(ca.n))];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && wsel(cmd, MAT_OUT)) wo_mem[we_addr] <= w_sat;
    wo_b <= wo_mem[EAW'(int'(ca.o) * MD + int'(ca.n))];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && wsel(cmd, MAT_QUERY)) wq_mem[ws_addr] <= w_sat;
    wq_b <= wq_mem[SAW'(int'(ca.m) * MD + int'(ca.n))];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && wsel(cmd, MAT_KEY)) wk_mem[ws_addr] <= w_sat;
    wk_b <= wk_mem[SAW'(int'(ca.m) * MD + int'(ca.n))];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && wsel(cmd, MAT_VALUE)) wv_mem[ws_addr] <= w_sat;
    wv_b <= wv_mem[SAW'(int'(ca.m) * MD + int'(ca.n))];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_TOKEN) tok_mem[PW'(cmd.position)] <= cmd.token;
    tok_a <= tok_mem[PW'(c0.o)];
  end

  always_ff @(posedge clk) begin
    xok_b <= int'(tok_a) < VOCAB;
  end

  always_ff @(posedge clk) begin
    if (cc.valid && cc.last && phase == PH_KVQ) begin
      k_mem[KAW'(int'(cc.o) * MD + int'(cc.m))] <= sat_d(rnd(sum0));
    end
    k_b <= k_mem[KAW'(int'(ca.o) * MD + int'(ca.n))];
  end

  always_ff @(posedge clk) begin
    if (cc.valid && cc.last && phase == PH_KVQ) begin
      v_mem[KAW'(int'(cc.o) * MD + int'(cc.m))] <= sat_d(rnd(sum1));
    end
    v_b <= v_mem[KAW'(int'(ca.o) * MD + int'(ca.m))];
  end

  always_ff @(posedge clk) begin
    if (cc.valid && cc.last && phase == PH_KVQ && int'(cc.o) == int'(pos_r)) begin
      q_mem[cc.m] <= sat_d(rnd(sum2));
    end
    q_b <= q_mem[ca.n];
  end

  always_ff @(posedge clk) begin
    if (state == S_DV_WAIT && div_done) y_mem[dv_d] <= y_next;
    y_b <= y_mem[ca.n];
  end

  assign acc_ra = (state == S_DV_RD || state == S_DV_GO) ? dv_d : ca.m;

  always_ff @(posedge clk) begin
    if (cc.valid && phase == PH_AC) begin
      acc_mem[cc.m] <= ((cc.o == '0) ? '0 : acc_c) + ext(p0);
    end
    acc_b <= acc_mem[acc_ra];
  end

  // ---- multiply stage ----
  assign x_b = xok_b ? emb_b : '0;

  always_comb begin
    case (phase)
      PH_KVQ:  begin ma = sx(wk_b);            mb = sx(x_b); end
      PH_SC:   begin ma = sx(q_b);             mb = sx(k_b); end
      PH_AC:   begin ma = $signed({1'b0, w});  mb = sx(v_b); end
      PH_LG:   begin ma = sx(wo_b);            mb = sx(y_b); end
      default: begin ma = sx(wk_b);            mb = sx(x_b); end
    endcase
  end

  always_ff @(posedge clk) begin
    p0    <= ma * mb;
    p1    <= sx(wv_b) * sx(x_b);
    p2    <= sx(wq_b) * sx(x_b);
    acc_c <= acc_b;
  end

  // ---- accumulate stage ----
  assign sum0 = (cc.first ? '0 : acc0) + ext(p0);
  assign sum1 = (cc.first ? '0 : acc1) + ext(p1);
  assign sum2 = (cc.first ? '0 : acc2) + ext(p2);

  always_ff @(posedge clk) begin
    if (cc.valid) begin
      acc0 <= sum0;
      acc1 <= sum1;
      acc2 <= sum2;
    end
  end

  // ---- attention weight ----
  always_comb begin
    score_x = $signed({{(ACCW - DW){score[DW-1]}}, score});
    neg_x   = ((-score_x) + $signed(ACCW'(32))) >>> 6;
    exp_idx = (neg_x > 255) ? 8'hFF : neg_x[7:0];
    if (score > 0) begin
      w_next = WW'($unsigned(sat_d(score_x + $signed(ACCW'(ONE_Q)))));
    end else begin
      w_next = WW'(EXP_ROM[exp_idx*16 +: 16]);
    end
  end

  // ---- normalization ----
  assign acc_mag   = acc_b[ACCW-1] ? ACCW'(-acc_b) : ACCW'(acc_b);
  assign div_num   = NW'(acc_mag) + NW'(z >> 1);
  assign div_start = state == S_DV_GO;

  lafu_div #(.NW(NW), .ZW(ZW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (z),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (dv_neg) begin
      y_next = (div_q > NW'(SAT_MAX)) ? DW'(SAT_MIN) : DW'(-$signed({1'b0, div_q}));
    end else begin
      y_next = (div_q > NW'(SAT_MAX)) ? DW'(SAT_MAX) : DW'(div_q);
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_KVQ;
      o            <= '0;
      m            <= '0;
      n            <= '0;
      dv_d         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cc.valid && cc.last && phase == PH_LG) begin
        result_valid       <= 1'b1;
        result.logit_index <= 5'(cc.o);
        result.logit       <= clamp24(rnd(sum0));
        result.last        <= int'(cc.o) == NRES - 1;
      end
      if (cc.valid && cc.last && phase == PH_SC) begin
        score <= sat_d(rnd(sum0));
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.kind == CMD_COMPUTE) begin
            pos_r <= cmd.position;
            z     <= ZW'(1);
            phase <= PH_KVQ;
            o     <= '0;
            m     <= '0;
            n     <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!n_wrap) begin
            n <= n + IW'(1);
          end else begin
            n <= '0;
            if (!m_wrap) begin
              m <= m + IW'(1);
            end else begin
              m <= '0;
              if (!o_wrap) begin
                o <= o + OW'(1);
              end else begin
                state <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          if (pipe_empty) begin
            case (phase)
              PH_KVQ: begin
                phase <= PH_SC;
                o     <= '0;
                state <= S_RUN;
              end
              PH_SC: state <= S_WGT;
              PH_AC: begin
                if (int'(o) == SEQ_LEN - 1) begin
                  dv_d  <= '0;
                  state <= S_DV_RD;
                end else begin
                  o     <= o + OW'(1);
                  phase <= PH_SC;
                  state <= S_RUN;
                end
              end
              PH_LG:   state <= S_IDLE;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_WGT: begin
          w     <= w_next;
          z     <= z + ZW'(w_next);
          phase <= PH_AC;
          m     <= '0;
          n     <= '0;
          state <= S_RUN;
        end
        S_DV_RD: state <= S_DV_GO;
        S_DV_GO: begin
          dv_neg <= acc_b[ACCW-1];
          state  <= S_DV_WAIT;
        end
        S_DV_WAIT: begin
          if (div_done) begin
            if (int'(dv_d) == MD - 1) begin
              phase <= PH_LG;
              o     <= '0;
              m     <= '0;
              n     <= '0;
              state <= S_RUN;
            end else begin
              dv_d  <= dv_d + IW'(1);
              state <= S_DV_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/linear_attention_forward_unit.sv =====
// Weight and token loads: one beat per cycle while busy is low; each is queued, then written when the back end is idle.
// Compute beat: projection, score, attention, normalize and logit phases run in turn, fed
//   by one issue sequencer (three multiply-accumulates while projecting, one in the other
//   multiply phases); queued beats wait behind it.
// Logits come out one at a time in index order; the receiver cannot stall.
// Reset (rst, synchronous) empties the queue and idles the sequencer; weights unset.
`default_nettype none
module linear_attention_forward_unit import lafu_pkg::*; #(
  parameter int VOCAB      = VOCAB_DEF,
  parameter int MODEL_DIM  = MODEL_DIM_DEF,
  parameter int SEQ_LEN    = SEQ_LEN_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t request,
  output logic      busy,
  output logic      result_valid,
  output res_t      result
);

  // front: decode and range-check each beat
  logic push;
  cmd_t push_cmd;
  logic full;

  // queue head toward the back end
  logic head_valid;
  cmd_t head;
  logic pop;

  lafu_front #(
    .VOCAB     (VOCAB),
    .MODEL_DIM (MODEL_DIM),
    .SEQ_LEN   (SEQ_LEN)
  ) u_front (
    .start   (start),
    .request (request),
    .full    (full),
    .busy    (busy),
    .push    (push),
    .cmd     (push_cmd)
  );

  // short command queue; busy only when it is full
  lafu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (full)
  );

  // back end: weight stores, projection / score / attend / normalize / logit sequencer
  lafu_back #(
    .VOCAB      (VOCAB),
    .MODEL_DIM  (MODEL_DIM),
    .SEQ_LEN    (SEQ_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (head_valid),
    .cmd          (head),
    .cmd_pop      (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire
